// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/crfb_pkg.sv =====
// ----------------------------------------------------------------------------
// crfb_pkg
// Shared widths, command codes, register indexes and types of the blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package crfb_pkg;

    localparam int CMD_W       = 3;
    localparam int POS_W       = 16;
    localparam int SIZE_W      = 15;
    localparam int COLOR_W     = 32;
    localparam int SCR_W       = 8;
    localparam int CFG_IDX_W   = 1;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_PIXEL_BITS = 32;

    localparam logic [SCR_W-1:0] SCREEN_RESET = 8'd128;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILL_SCREEN = 3'd0,
        CMD_FILL_RECT   = 3'd1,
        CMD_BEGIN_BLIT  = 3'd2,
        CMD_BLIT_PIXEL  = 3'd3,
        CMD_READ_PIXEL  = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic busy;
        logic last;
    } t_fill_stat;

endpackage

`default_nettype wire

// ===== rtl/core/crfb_ifs.sv =====
// ----------------------------------------------------------------------------
// crfb_ifs
// Valid/ready channels of the blitter: commands, read results, configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface crfb_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [crfb_pkg::CMD_W-1:0]          command;
    logic signed [crfb_pkg::POS_W-1:0]   pos_x;
    logic signed [crfb_pkg::POS_W-1:0]   pos_y;
    logic [crfb_pkg::SIZE_W-1:0]         size_w;
    logic [crfb_pkg::SIZE_W-1:0]         size_h;
    logic [crfb_pkg::COLOR_W-1:0]        color;

    modport source (output valid, command, pos_x, pos_y, size_w, size_h, color,
                    input ready);
    modport sink (input valid, command, pos_x, pos_y, size_w, size_h, color,
                  output ready);
endinterface

interface crfb_pix_if;
    logic                          valid;
    logic                          ready;
    logic [crfb_pkg::COLOR_W-1:0]  pixel;
    logic                          on_screen;

    modport source (output valid, pixel, on_screen, input ready);
    modport sink (input valid, pixel, on_screen, output ready);
endinterface

interface crfb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [crfb_pkg::CFG_IDX_W-1:0]  index;
    logic [crfb_pkg::SCR_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/crfb_frame_mem.sv =====
// ----------------------------------------------------------------------------
// crfb_frame_mem
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crfb_frame_mem #(
    parameter int MAX_WIDTH  = crfb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crfb_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = crfb_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_wr_en,
    input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]       i_wr_addr,
    input  wire logic [PIXEL_BITS-1:0]                         i_wr_data,
    input  wire logic                                          i_rd_en,
    input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]       i_rd_addr,
    output      logic [PIXEL_BITS-1:0]                         o_rd_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [PIXEL_BITS-1:0] r_mem [DEPTH];
    logic [PIXEL_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/crfb_fill_walk.sv =====
// ----------------------------------------------------------------------------
// crfb_fill_walk
// Walks a clipped rectangle in raster order, one frame store write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crfb_fill_walk #(
    parameter int MAX_WIDTH  = crfb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crfb_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = crfb_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_start,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]             i_x0,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]           i_x1,
    input  wire logic [$clog2(MAX_HEIGHT)-1:0]            i_y0,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]          i_y1,
    input  wire logic [PIXEL_BITS-1:0]                    i_color,
    output      crfb_pkg::t_fill_stat                     o_stat,
    output      logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  o_wr_addr,
    output      logic [PIXEL_BITS-1:0]                    o_wr_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int CH = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    logic                   r_busy;
    logic [XW-1:0]          r_col;
    logic [XW-1:0]          r_x0;
    logic [CW-1:0]          r_x1;
    logic [YW-1:0]          r_row;
    logic [CH-1:0]          r_y1;
    logic [AW-1:0]          r_base;
    logic [PIXEL_BITS-1:0]  r_color;

    logic col_last;
    logic row_last;

    assign col_last = (CW'(r_col) + CW'(1)) == r_x1;
    assign row_last = (CH'(r_row) + CH'(1)) == r_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && col_last && row_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_col   <= i_x0;
            r_x0    <= i_x0;
            r_x1    <= i_x1;
            r_row   <= i_y0;
            r_y1    <= i_y1;
            r_base  <= AW'(i_y0) * AW'(MAX_WIDTH);
            r_color <= i_color;
        end else if (r_busy) begin
            if (col_last) begin
                r_col  <= r_x0;
                r_row  <= r_row + YW'(1);
                r_base <= r_base + AW'(MAX_WIDTH);
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.last = r_busy && col_last && row_last;
    assign o_wr_addr   = r_base + AW'(r_col);
    assign o_wr_data   = r_color;

endmodule

`default_nettype wire

// ===== rtl/core/crfb_blit_seq.sv =====
// ----------------------------------------------------------------------------
// crfb_blit_seq
// Blit origin, size and raster position; clips each source pixel to screen.
// ----------------------------------------------------------------------------
`default_nettype none

module crfb_blit_seq #(
    parameter int MAX_WIDTH  = crfb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crfb_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_load,
    input  wire logic                                     i_step,
    input  wire logic signed [crfb_pkg::POS_W-1:0]        i_pos_x,
    input  wire logic signed [crfb_pkg::POS_W-1:0]        i_pos_y,
    input  wire logic [crfb_pkg::SIZE_W-1:0]              i_size_w,
    input  wire logic [crfb_pkg::SIZE_W-1:0]              i_size_h,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]           i_eff_w,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]          i_eff_h,
    output      logic                                     o_wr_en,
    output      logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  o_wr_addr
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int SW = crfb_pkg::POS_W + 2;

    logic signed [crfb_pkg::POS_W-1:0]  r_origin_x;
    logic signed [crfb_pkg::POS_W-1:0]  r_origin_y;
    logic [crfb_pkg::SIZE_W-1:0]        r_width;
    logic [crfb_pkg::SIZE_W-1:0]        r_height;
    logic [crfb_pkg::SIZE_W-1:0]        r_col;
    logic [crfb_pkg::SIZE_W-1:0]        r_row;

    logic                  active;
    logic                  col_wrap;
    logic signed [SW-1:0]  dx;
    logic signed [SW-1:0]  dy;
    logic signed [SW-1:0]  eff_w_s;
    logic signed [SW-1:0]  eff_h_s;
    logic                  on_x;
    logic                  on_y;

    assign active   = (r_width != '0) && (r_row < r_height);
    assign col_wrap = (r_col + crfb_pkg::SIZE_W'(1)) >= r_width;
    assign dx       = SW'(r_origin_x) + SW'(r_col);
    assign dy       = SW'(r_origin_y) + SW'(r_row);
    assign eff_w_s  = SW'(i_eff_w);
    assign eff_h_s  = SW'(i_eff_h);
    assign on_x     = !dx[SW-1] && (dx < eff_w_s);
    assign on_y     = !dy[SW-1] && (dy < eff_h_s);

    assign o_wr_en   = i_step && active && on_x && on_y;
    assign o_wr_addr = AW'(dy[YW-1:0]) * AW'(MAX_WIDTH) + AW'(dx[XW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_load) begin
            r_origin_x <= i_pos_x;
            r_origin_y <= i_pos_y;
            r_width    <= i_size_w;
            r_height   <= i_size_h;
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_step && active) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= r_row + crfb_pkg::SIZE_W'(1);
            end else begin
                r_col <= r_col + crfb_pkg::SIZE_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/clipped_rect_fill_and_blit_unit.sv =====
// ----------------------------------------------------------------------------
// clipped_rect_fill_and_blit_unit
// 2D blitter with a frame store: screen and rectangle fill, clipped blit,
// pixel read back.
// ----------------------------------------------------------------------------
// Begin blit and blit pixel transactions stream back to back; each on screen
// blit pixel writes the frame store at its accepting edge. A fill walks the
// clipped rectangle in raster order through the single write port of the
// frame store; the command channel is held off meanwhile. An on screen read
// passes the registered read port and the ST_READ state; an off screen read
// is answered at the accepting edge. The result sits in an output register,
// so other commands keep flowing while it waits; a further read is held off
// until that result is taken. The frame store needs no clearing pass after
// reset; reading a pixel never written is undefined.
`default_nettype none

module clipped_rect_fill_and_blit_unit #(
    parameter int MAX_WIDTH  = crfb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crfb_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = crfb_pkg::DEF_PIXEL_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    crfb_cmd_if.sink   i_cmd,
    crfb_pix_if.source o_pix,
    crfb_cfg_if.sink   i_cfg
);

    `include "assert_macros.svh"

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int CH = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int EW = (CW > crfb_pkg::SCR_W) ? CW : crfb_pkg::SCR_W;
    localparam int EH = (CH > crfb_pkg::SCR_W) ? CH : crfb_pkg::SCR_W;
    localparam int SW = crfb_pkg::POS_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_FILL = 3'b010,
        ST_READ = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [crfb_pkg::SCR_W-1:0]    r_scr_w;
    logic [crfb_pkg::SCR_W-1:0]    r_scr_h;
    logic                          r_out_valid;
    logic [crfb_pkg::COLOR_W-1:0]  r_out_pixel;
    logic                          r_out_on;

    logic [EW-1:0]  eff_w_wide;
    logic [EH-1:0]  eff_h_wide;
    logic [CW-1:0]  eff_w;
    logic [CH-1:0]  eff_h;

    logic cmd_accept;
    logic out_free;
    logic fill_screen;

    logic signed [SW-1:0]  fx;
    logic signed [SW-1:0]  fy;
    logic signed [SW-1:0]  fw;
    logic signed [SW-1:0]  fh;
    logic signed [SW-1:0]  x0s;
    logic signed [SW-1:0]  y0s;
    logic signed [SW-1:0]  x1_raw;
    logic signed [SW-1:0]  y1_raw;
    logic signed [SW-1:0]  x1s;
    logic signed [SW-1:0]  y1s;
    logic signed [SW-1:0]  eff_w_s;
    logic signed [SW-1:0]  eff_h_s;
    logic                  fill_nonempty;

    logic             rd_on;
    logic [AW-1:0]    rd_addr;

    logic                          fill_start;
    logic                          blit_load;
    logic                          blit_step;
    logic                          rd_en;
    logic                          out_load;
    logic [crfb_pkg::COLOR_W-1:0]  out_pixel;
    logic                          out_on;

    crfb_pkg::t_fill_stat      w_fill_stat;
    logic [AW-1:0]             w_fill_addr;
    logic [PIXEL_BITS-1:0]     w_fill_data;
    logic                      w_blit_wr_en;
    logic [AW-1:0]             w_blit_addr;
    logic                      mem_wr_en;
    logic [AW-1:0]             mem_wr_addr;
    logic [PIXEL_BITS-1:0]     mem_wr_data;
    logic [PIXEL_BITS-1:0]     w_rd_data;

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= crfb_pkg::SCREEN_RESET;
            r_scr_h <= crfb_pkg::SCREEN_RESET;
        end else if (i_cfg.valid) begin
            case (crfb_pkg::t_cfg_idx'(i_cfg.index))
                crfb_pkg::CFG_SCREEN_WIDTH: begin
                    r_scr_w <= i_cfg.data;
                end
                crfb_pkg::CFG_SCREEN_HEIGHT: begin
                    r_scr_h <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    assign eff_w_wide = (EW'(r_scr_w) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(r_scr_w);
    assign eff_h_wide = (EH'(r_scr_h) > EH'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : EH'(r_scr_h);
    assign eff_w      = CW'(eff_w_wide);
    assign eff_h      = CH'(eff_h_wide);
    assign eff_w_s    = SW'(eff_w);
    assign eff_h_s    = SW'(eff_h);

    // Handshake
    assign out_free     = !r_out_valid || o_pix.ready;
    assign i_cmd.ready  = (r_state == ST_IDLE) &&
                          (out_free || (i_cmd.command != crfb_pkg::CMD_READ_PIXEL));
    assign cmd_accept   = i_cmd.valid && i_cmd.ready;

    // Fill clipping
    assign fill_screen   = i_cmd.command == crfb_pkg::CMD_FILL_SCREEN;
    assign fx            = fill_screen ? '0 : SW'(i_cmd.pos_x);
    assign fy            = fill_screen ? '0 : SW'(i_cmd.pos_y);
    assign fw            = fill_screen ? eff_w_s : SW'(i_cmd.size_w);
    assign fh            = fill_screen ? eff_h_s : SW'(i_cmd.size_h);
    assign x0s           = fx[SW-1] ? '0 : fx;
    assign y0s           = fy[SW-1] ? '0 : fy;
    assign x1_raw        = fx + fw;
    assign y1_raw        = fy + fh;
    assign x1s           = (x1_raw > eff_w_s) ? eff_w_s : x1_raw;
    assign y1s           = (y1_raw > eff_h_s) ? eff_h_s : y1_raw;
    assign fill_nonempty = (x1s > x0s) && (y1s > y0s);

    // Read addressing
    assign rd_on   = !i_cmd.pos_x[crfb_pkg::POS_W-1] && !i_cmd.pos_y[crfb_pkg::POS_W-1] &&
                     (i_cmd.pos_x[crfb_pkg::POS_W-2:0] < (crfb_pkg::POS_W-1)'(eff_w)) &&
                     (i_cmd.pos_y[crfb_pkg::POS_W-2:0] < (crfb_pkg::POS_W-1)'(eff_h));
    assign rd_addr = AW'(i_cmd.pos_y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(i_cmd.pos_x[XW-1:0]);

    // Command sequencing
    always_comb begin
        n_state    = r_state;
        fill_start = 1'b0;
        blit_load  = 1'b0;
        blit_step  = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        out_pixel  = '0;
        out_on     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (cmd_accept) begin
                    case (crfb_pkg::t_cmd'(i_cmd.command))
                        crfb_pkg::CMD_FILL_SCREEN,
                        crfb_pkg::CMD_FILL_RECT: begin
                            if (fill_nonempty) begin
                                fill_start = 1'b1;
                                n_state    = ST_FILL;
                            end
                        end
                        crfb_pkg::CMD_BEGIN_BLIT: begin
                            blit_load = 1'b1;
                        end
                        crfb_pkg::CMD_BLIT_PIXEL: begin
                            blit_step = 1'b1;
                        end
                        crfb_pkg::CMD_READ_PIXEL: begin
                            if (rd_on) begin
                                rd_en   = 1'b1;
                                n_state = ST_READ;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                if (w_fill_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                out_load  = 1'b1;
                out_pixel = crfb_pkg::COLOR_W'(w_rd_data);
                out_on    = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pixel <= out_pixel;
            r_out_on    <= out_on;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.pixel     = r_out_pixel;
    assign o_pix.on_screen = r_out_on;

    // Datapath units
    crfb_fill_walk #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_fill (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (fill_start),
        .i_x0      (XW'(x0s)),
        .i_x1      (CW'(x1s)),
        .i_y0      (YW'(y0s)),
        .i_y1      (CH'(y1s)),
        .i_color   (PIXEL_BITS'(i_cmd.color)),
        .o_stat    (w_fill_stat),
        .o_wr_addr (w_fill_addr),
        .o_wr_data (w_fill_data)
    );

    crfb_blit_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_blit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (blit_load),
        .i_step    (blit_step),
        .i_pos_x   (i_cmd.pos_x),
        .i_pos_y   (i_cmd.pos_y),
        .i_size_w  (i_cmd.size_w),
        .i_size_h  (i_cmd.size_h),
        .i_eff_w   (eff_w),
        .i_eff_h   (eff_h),
        .o_wr_en   (w_blit_wr_en),
        .o_wr_addr (w_blit_addr)
    );

    assign mem_wr_en   = w_fill_stat.busy || w_blit_wr_en;
    assign mem_wr_addr = w_fill_stat.busy ? w_fill_addr : w_blit_addr;
    assign mem_wr_data = w_fill_stat.busy ? w_fill_data : PIXEL_BITS'(i_cmd.color);

    crfb_frame_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Checks
    `ASSERT_IMPLIES(a_fill_busy_state, i_clk, i_rst_n, 1'b1, (r_state == ST_FILL) == w_fill_stat.busy)
    `ASSERT_IMPLIES(a_no_write_clash, i_clk, i_rst_n, w_fill_stat.busy, !w_blit_wr_en)
    `ASSERT_NEXT(a_read_returns, i_clk, i_rst_n, r_state == ST_READ, r_out_valid && r_out_on)
    `ASSERT_IMPLIES(a_read_slot_free, i_clk, i_rst_n, r_state == ST_READ, !r_out_valid)

endmodule

`default_nettype wire
